@@ rtl/websocket_frame_deframer_defines.svh @@
// assertion macros shared by the frame deframer modules
// no dependencies; included by every module that carries checks
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check that is disabled while reset is high
`define WSFD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds during reset
`define WSFD_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WSFD_CHECK(lbl, prop, msg)
`define WSFD_CHECK_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/wsfd_pkg.sv @@
// types and constants of the frame deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package wsfd_pkg;

  // default width of the payload length counter
  localparam int LENGTH_WIDTH_DEF = 64;

  // opcodes and length codes
  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // extended length byte counts, minus one
  localparam logic [2:0] EXT_BYTES_16 = 3'd1;
  localparam logic [2:0] EXT_BYTES_64 = 3'd7;

  // last index of the 4-byte mask key
  localparam logic [1:0] KEY_LAST = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_STOP = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD     = 2'd0,
    KIND_EMPTY       = 2'd1,
    KIND_CLOSE       = 2'd2,
    KIND_UNSUPPORTED = 2'd3
  } kind_t;

  // one result item, handed from the parser to the output stage
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

endpackage

@@ rtl/wsfd_parser.sv @@
// input register and frame parse state of the deframer
// depends on wsfd_pkg and websocket_frame_deframer_defines.svh
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"

module wsfd_parser
  import wsfd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       out_ready,
  output logic       res_load,
  output result_t    res
);

  localparam int LW = LENGTH_WIDTH;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // parse state
  phase_t          phase, phase_next;
  logic [2:0]      ext_count, ext_count_next;
  logic            masked, masked_next;
  logic [7:0]      key_bytes [4];
  logic [LW-1:0]   remaining, remaining_next;
  logic            ovf, ovf_next;
  logic [1:0]      key_index, key_index_next;

  // helpers
  logic            advance;
  logic [6:0]      code;
  logic [LW-1:0]   shifted;
  logic            shift_ovf;
  logic            len_done;
  logic            masked_eff;
  logic [LW-1:0]   len_val;
  logic            key_done;

  assign advance       = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  // length decode shared by both state blocks
  assign code      = in_byte[6:0];
  assign shifted   = {remaining[LW-9:0], in_byte};
  assign shift_ovf = ovf || (remaining[LW-1:LW-8] != 8'd0);
  assign key_done  = (phase == PH_KEY) && (key_index == KEY_LAST);

  always_comb begin
    len_done   = 1'b0;
    masked_eff = masked;
    len_val    = shifted;
    if (phase == PH_LEN) begin
      masked_eff = in_byte[7];
      len_val    = {{(LW-7){1'b0}}, code};
      len_done   = (code != LEN_CODE_16) && (code != LEN_CODE_64);
    end else if (phase == PH_EXT) begin
      len_val  = shift_ovf ? {LW{1'b1}} : shifted;
      len_done = (ext_count == 3'd0);
    end
  end

  // next state
  always_comb begin
    phase_next     = phase;
    ext_count_next = ext_count;
    masked_next    = masked;
    remaining_next = remaining;
    ovf_next       = ovf;
    key_index_next = key_index;
    if (advance) begin
      unique case (phase)
        PH_HDR: begin
          if (!in_byte[7] || in_byte[3:0] != OP_TEXT) begin
            phase_next = PH_STOP;
          end else begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN, PH_EXT: begin
          masked_next = masked_eff;
          if (phase == PH_LEN) begin
            ovf_next       = 1'b0;
            remaining_next = '0;
            ext_count_next = (code == LEN_CODE_64) ? EXT_BYTES_64 : EXT_BYTES_16;
          end else begin
            ovf_next       = shift_ovf;
            remaining_next = shifted;
            ext_count_next = ext_count - 3'd1;
          end
          if (!len_done) begin
            phase_next = PH_EXT;
          end else begin
            remaining_next = len_val;
            key_index_next = 2'd0;
            if (masked_eff) begin
              phase_next = PH_KEY;
            end else if (len_val == '0) begin
              phase_next = PH_HDR;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_KEY: begin
          key_index_next = key_index + 2'd1;
          if (key_done) begin
            phase_next = (remaining == '0) ? PH_HDR : PH_DATA;
          end
        end
        PH_DATA: begin
          key_index_next = key_index + 2'd1;
          remaining_next = remaining - {{(LW-1){1'b0}}, 1'b1};
          if (remaining == {{(LW-1){1'b0}}, 1'b1}) begin
            phase_next = PH_HDR;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // result of the byte being parsed
  always_comb begin
    res_load  = 1'b0;
    res.data  = 8'd0;
    res.kind  = KIND_PAYLOAD;
    res.last  = 1'b1;
    unique case (phase)
      PH_HDR: begin
        res_load = 1'b1;
        if (!in_byte[7]) begin
          res.kind = KIND_UNSUPPORTED;
        end else if (in_byte[3:0] == OP_CLOSE) begin
          res.kind = KIND_CLOSE;
        end else if (in_byte[3:0] != OP_TEXT) begin
          res.kind = KIND_UNSUPPORTED;
        end else begin
          res_load = 1'b0;
        end
      end
      PH_LEN, PH_EXT: begin
        res_load = len_done && !masked_eff && (len_val == '0);
        res.kind = KIND_EMPTY;
      end
      PH_KEY: begin
        res_load = key_done && (remaining == '0);
        res.kind = KIND_EMPTY;
      end
      PH_DATA: begin
        res_load = 1'b1;
        res.data = masked ? (in_byte ^ key_bytes[key_index]) : in_byte;
        res.last = (remaining == {{(LW-1){1'b0}}, 1'b1});
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
    res_load = res_load && advance;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR;
      ext_count <= 3'd0;
      masked    <= 1'b0;
      remaining <= '0;
      ovf       <= 1'b0;
      key_index <= 2'd0;
    end else begin
      phase     <= phase_next;
      ext_count <= ext_count_next;
      masked    <= masked_next;
      remaining <= remaining_next;
      ovf       <= ovf_next;
      key_index <= key_index_next;
    end
  end

  // mask key capture
  always_ff @(posedge clk) begin
    if (advance && phase == PH_KEY) begin
      key_bytes[key_index] <= in_byte;
    end
  end

  // checks
  `WSFD_CHECK(a_stop_sticks, phase == PH_STOP |=> phase == PH_STOP, "stopped parser resumed")
  `WSFD_CHECK(a_stop_silent, phase == PH_STOP |-> !res_load, "result after stop")
  `WSFD_CHECK(a_data_nonzero, phase == PH_DATA |-> remaining != '0, "payload phase with no bytes left")
  `WSFD_CHECK(a_data_entry, (phase != PH_DATA && phase_next == PH_DATA) |-> key_index_next == 2'd0, "payload starts off key index zero")

endmodule

@@ rtl/wsfd_out_stage.sv @@
// result register driving the master stream side
// depends on wsfd_pkg and websocket_frame_deframer_defines.svh
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"

module wsfd_out_stage
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       res_load,
  input  result_t    res,
  output logic       out_ready,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic [1:0] m_axis_tuser,   // kind
  output logic       m_axis_tlast
);

  result_t held;

  assign out_ready = !m_axis_tvalid || m_axis_tready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_load) begin
      held <= res;
    end
  end

  assign m_axis_tdata = held.data;
  assign m_axis_tuser = held.kind;
  assign m_axis_tlast = held.last;

  // checks
  `WSFD_CHECK(a_status_last, (m_axis_tvalid && held.kind != KIND_PAYLOAD) |-> (held.last && held.data == 8'd0), "status result not marked last")
  `WSFD_CHECK_ALWAYS(a_load_room, res_load |-> out_ready, "result loaded over a waiting transfer")

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// WebSocket receive-side frame deframer, top level
// depends on wsfd_pkg, wsfd_parser and wsfd_out_stage
//
// Usage:
//   s_axis carries the received frame stream, one byte per transfer in tdata.
//   m_axis carries results: tdata is the unmasked payload byte (zero for
//   status results), tuser the kind (payload, empty text message, close,
//   unsupported) and tlast marks the final payload byte or a status result.
//   Each input byte is taken into an input register and parsed there against
//   the frame state; its result, if any, is loaded into the output register
//   once that register has room, and m_axis_tvalid rises with it.
//   One byte per cycle is sustained while m_axis_tready stays high; the parse
//   state update is the only path between the two registers.
//   Reset returns the parser to waiting for a header byte and empties both
//   registers. After a close or unsupported frame every further byte is
//   taken and dropped until reset.
//   When m_axis_tready is low with a result waiting, the parser holds its
//   byte and s_axis_tready falls once the input register is occupied.
`timescale 1ns / 1ps

module websocket_frame_deframer
  import wsfd_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic [1:0] m_axis_tuser,   // kind
  output logic       m_axis_tlast
);

  logic    out_ready;
  logic    res_load;
  result_t res;

  // header, length, key and payload parsing
  wsfd_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .out_ready    (out_ready),
    .res_load     (res_load),
    .res          (res)
  );

  // result register
  wsfd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res          (res),
    .out_ready    (out_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

@@ tb/sv/tb_websocket_frame_deframer.sv @@
// self-checking testbench for websocket_frame_deframer
// depends on wsfd_pkg and the deframer rtl; a scoreboard class predicts every result
`timescale 1ns / 1ps

// byte-level frame parser and store of expected results
class frame_scoreboard;
  wsfd_pkg::result_t    deframed_q[$];
  int                   mismatches;
  int                   accepted;
  wsfd_pkg::phase_t     ph;
  logic [2:0]           ext_left;
  logic                 masked;
  logic [7:0]           key_bytes[4];
  logic [63:0]          remaining;
  logic [1:0]           key_idx;

  function new();
    mismatches = 0;
    accepted   = 0;
    ph         = wsfd_pkg::PH_HDR;
    ext_left   = '0;
    masked     = 1'b0;
    remaining  = '0;
    key_idx    = '0;
    foreach (key_bytes[i]) key_bytes[i] = '0;
  endfunction

  function int pending();
    return deframed_q.size();
  endfunction

  // close or unsupported frame: one status result, then the parser stops
  function void halt(wsfd_pkg::kind_t k);
    ph = wsfd_pkg::PH_STOP;
    deframed_q.push_back('{8'h00, k, 1'b1});
  endfunction

  // payload begins, or an empty message is reported right away
  function void start_payload();
    key_idx = '0;
    if (remaining == 0) begin
      ph = wsfd_pkg::PH_HDR;
      deframed_q.push_back('{8'h00, wsfd_pkg::KIND_EMPTY, 1'b1});
    end else begin
      ph = wsfd_pkg::PH_DATA;
    end
  endfunction

  function void length_done();
    if (masked) begin
      ph      = wsfd_pkg::PH_KEY;
      key_idx = '0;
    end else begin
      start_payload();
    end
  endfunction

  // advance the parse state by one accepted input byte
  function void parse_byte(logic [7:0] b);
    logic [63:0] limit;
    logic [7:0]  v;
    limit = {64{1'b1}} >> (64 - wsfd_pkg::LENGTH_WIDTH_DEF);
    accepted++;
    case (ph)
      wsfd_pkg::PH_HDR: begin
        if (!b[7]) halt(wsfd_pkg::KIND_UNSUPPORTED);
        else if (b[3:0] == wsfd_pkg::OP_CLOSE) halt(wsfd_pkg::KIND_CLOSE);
        else if (b[3:0] != wsfd_pkg::OP_TEXT) halt(wsfd_pkg::KIND_UNSUPPORTED);
        else ph = wsfd_pkg::PH_LEN;
      end
      wsfd_pkg::PH_LEN: begin
        masked    = b[7];
        remaining = '0;
        if (b[6:0] == wsfd_pkg::LEN_CODE_16) begin
          ext_left = wsfd_pkg::EXT_BYTES_16;
          ph       = wsfd_pkg::PH_EXT;
        end else if (b[6:0] == wsfd_pkg::LEN_CODE_64) begin
          ext_left = wsfd_pkg::EXT_BYTES_64;
          ph       = wsfd_pkg::PH_EXT;
        end else begin
          remaining = {57'd0, b[6:0]};
          length_done();
        end
      end
      wsfd_pkg::PH_EXT: begin
        remaining = {remaining[55:0], b};
        if (ext_left != 0) begin
          ext_left = ext_left - 3'd1;
        end else begin
          if (remaining > limit) remaining = limit;
          length_done();
        end
      end
      wsfd_pkg::PH_KEY: begin
        key_bytes[key_idx] = b;
        key_idx = key_idx + 2'd1;
        if (key_idx == 0) start_payload();
      end
      wsfd_pkg::PH_DATA: begin
        v         = masked ? (b ^ key_bytes[key_idx]) : b;
        key_idx   = key_idx + 2'd1;
        remaining = remaining - 64'd1;
        deframed_q.push_back('{v, wsfd_pkg::KIND_PAYLOAD, remaining == 0});
        if (remaining == 0) ph = wsfd_pkg::PH_HDR;
      end
      default: ;
    endcase
  endfunction

  // compare one output transfer against the oldest prediction
  function void check_result(logic [7:0] d, logic [1:0] k, logic l);
    wsfd_pkg::result_t want;
    if (deframed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: data %02h kind %0d last %0d", d, k, l);
      return;
    end
    want = deframed_q.pop_front();
    if (want.data !== d || want.kind !== k || want.last !== l) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected data %02h kind %0d last %0d, got data %02h kind %0d last %0d",
                 want.data, want.kind, want.last, d, k, l);
    end
  endfunction
endclass

module tb_websocket_frame_deframer;
  import wsfd_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // in_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // out_byte
  logic [1:0] m_axis_tuser;           // kind
  logic       m_axis_tlast;

  frame_scoreboard sb;
  bit              sender_idle_on = 1'b1;
  bit              receiver_idle_on = 1'b1;
  int              results_seen = 0;

  websocket_frame_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one input transfer, after a random gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sb.accepted % 64 == 0) sender_idle_on = ($urandom_range(0, 3) != 0);
    gap = sender_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.parse_byte(b);
  endtask

  // one text frame; form 0 short length, 1 16-bit length, 2 64-bit length
  task automatic send_text_frame(input int len, input bit mask_on, input int form,
                                 input logic [31:0] key, input bit alternating);
    logic [63:0] len64;
    logic [7:0]  hdr;
    len64 = 64'(len);
    hdr   = 8'h80 | (8'($urandom_range(0, 7)) << 4) | {4'h0, OP_TEXT};
    send_byte(hdr);
    case (form)
      0: send_byte({mask_on, len64[6:0]});
      1: begin
        send_byte({mask_on, LEN_CODE_16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      default: begin
        send_byte({mask_on, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) send_byte(len64[i*8 +: 8]);
      end
    endcase
    if (mask_on) for (int i = 3; i >= 0; i--) send_byte(key[i*8 +: 8]);
    for (int i = 0; i < len; i++)
      send_byte(alternating ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom));
  endtask

  // random well-formed text frame, mostly short
  task automatic send_random_frame();
    int len;
    int form;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) len = 0;
    else if (pick < 60) len = $urandom_range(1, 8);
    else if (pick < 85) len = $urandom_range(9, 40);
    else if (pick < 95) len = $urandom_range(41, 125);
    else len = $urandom_range(126, 300);
    pick = $urandom_range(0, 99);
    if (len > 125) form = (pick < 60) ? 1 : 2;
    else form = (pick < 70) ? 0 : ((pick < 85) ? 1 : 2);
    send_text_frame(len, 1'($urandom_range(0, 1)), form, $urandom, 1'b0);
  endtask

  // result side: random stalls, check every transfer
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (results_seen % 50 == 0) receiver_idle_on = ($urandom_range(0, 3) != 0);
      gap = receiver_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_seen++;
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // main sequence
  initial begin
    bit   paused;
    int   stop_case;
    logic [3:0] op;
    sb     = new();
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty frames in short and 16-bit length forms, masked and not, then extreme data
    send_text_frame(0, 1'b0, 0, 32'h0, 1'b0);
    send_text_frame(0, 1'b1, 0, 32'hffffffff, 1'b0);
    send_text_frame(0, 1'b0, 1, 32'h0, 1'b0);
    send_text_frame(5, 1'b1, 0, 32'hff00ff00, 1'b1);

    // random well-formed frames
    while (sb.accepted < 1750) begin
      send_random_frame();
      if (!paused && sb.accepted > 875) begin
        // let every outstanding result drain before going on
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        paused = 1'b1;
      end
    end

    // final frame stops the parser: fin clear, close, or another opcode
    stop_case = $urandom_range(0, 2);
    case (stop_case)
      0: send_byte(8'($urandom) & 8'h7f);
      1: send_byte(8'h80 | (8'($urandom_range(0, 7)) << 4) | {4'h0, OP_CLOSE});
      default: begin
        do op = 4'($urandom); while (op == OP_TEXT || op == OP_CLOSE);
        send_byte(8'h80 | (8'($urandom_range(0, 7)) << 4) | {4'h0, op});
      end
    endcase
    // stopped parser drops everything
    repeat (8) send_byte(8'($urandom));
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS websocket_frame_deframer");
    end else begin
      $display("FAIL websocket_frame_deframer");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("FAIL websocket_frame_deframer");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/wsfd_out_stage.sv
rtl/websocket_frame_deframer.sv
tb/sv/tb_websocket_frame_deframer.sv
